FILE: hw/rtl/grid_nearest_star_match_top_macros.svh
// ----------------------------------------------------------------------------
// Grid nearest star match assertion macros
// Shared assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_NEAREST_STAR_MATCH_TOP_MACROS_SVH
`define GRID_NEAREST_STAR_MATCH_TOP_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define GNSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define GNSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/gnsm_pkg.sv
// ----------------------------------------------------------------------------
// Grid nearest star match package
// Types, constants and codes shared by the cross-matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gnsm_pkg;

  localparam int unsigned GridColsDef = 1024;
  localparam int unsigned GridRowsDef = 1024;
  localparam int unsigned MaxTmplDef  = 4096;

  localparam int unsigned OwnerW  = 13;
  localparam int unsigned CellW   = 15;
  localparam int unsigned SharedB = 13;
  localparam int unsigned CentreB = 14;
  localparam int unsigned BndW    = 13;
  localparam int unsigned DistW   = 33;
  localparam int unsigned TmplW   = 46;
  localparam int unsigned CfgW    = 13;

  localparam logic [DistW-1:0] ScanLimit = 33'd2560000;
  localparam logic [DistW-1:0] MissLimit = 33'd2304000;
  localparam logic [DistW-1:0] NoLimit   = '1;

  localparam logic [8:0]  RadiusRst = 9'd48;
  localparam logic [12:0] TolRst    = 13'd128;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_POS  = 2'd1,
    ST_MAG  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_MATCH_RADIUS = 1'b0,
    REG_MAG_TOL      = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             init;
    logic [DistW-1:0] limit;
  } eval_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic               found;
    logic [DistW-1:0]   best;
    logic signed [14:0] diff;
  } eval_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gnsm_ram.sv
// ----------------------------------------------------------------------------
// Grid nearest star match RAM
// Simple dual-port synchronous memory with one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gnsm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gnsm_eval.sv
// ----------------------------------------------------------------------------
// Grid nearest star match evaluator
// Three-stage distance pipeline that keeps the nearest template seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module gnsm_eval
  import gnsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire eval_ctrl_t         ctrl_i,
  input  wire logic               vld_i,
  input  wire logic [TmplW-1:0]   tmpl_i,
  input  wire logic [15:0]        qx_i,
  input  wire logic [15:0]        qy_i,
  input  wire logic signed [13:0] qmag_i,
  output eval_res_t               res_o
);

  logic               s1_vld_q, s2_vld_q;
  logic [15:0]        dx_q, dy_q;
  logic signed [14:0] d1_q, d2_q;
  logic [31:0]        dx2_q, dy2_q;
  logic [DistW-1:0]   best_q;
  logic signed [14:0] bdiff_q;
  logic               found_q;
  logic [15:0]        tx, ty;
  logic signed [13:0] tm;
  logic [DistW-1:0]   dsum;

  assign tx   = tmpl_i[45:30];
  assign ty   = tmpl_i[29:14];
  assign tm   = $signed(tmpl_i[13:0]);
  assign dsum = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      if (ctrl_i.init) begin
        found_q <= 1'b0;
      end else if (s2_vld_q && (dsum < best_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= (tx > qx_i) ? (tx - qx_i) : (qx_i - tx);
    dy_q  <= (ty > qy_i) ? (ty - qy_i) : (qy_i - ty);
    d1_q  <= $signed({tm[13], tm}) - $signed({qmag_i[13], qmag_i});
    dx2_q <= 32'(dx_q) * 32'(dx_q);
    dy2_q <= 32'(dy_q) * 32'(dy_q);
    d2_q  <= d1_q;
    if (ctrl_i.init) begin
      best_q <= ctrl_i.limit;
    end else if (s2_vld_q && (dsum < best_q)) begin
      best_q  <= dsum;
      bdiff_q <= d2_q;
    end
  end

  assign res_o.busy  = s1_vld_q | s2_vld_q;
  assign res_o.found = found_q;
  assign res_o.best  = best_q;
  assign res_o.diff  = bdiff_q;

endmodule

`default_nettype wire

FILE: hw/rtl/grid_nearest_star_match_top.sv
// ----------------------------------------------------------------------------
// Grid nearest star match top level
// Cross-matches image stars against template stars painted into a pixel grid.
// ----------------------------------------------------------------------------
// The input channel carries requests: clear, insert a template star, or
// query an image star. The output channel carries one result for a query
// that lands on an empty cell or misses in position or magnitude, and
// nothing for any other request. Configuration writes set the match radius
// and the magnitude tolerance. Items are taken one at a time; in_stall_o is
// high while one is in work. An insert or a shared-cell query walks a window
// of up to (2W+1)^2 cells with W = radius/16 + 2, so 121 cells at reset; the
// grid memory port, one cell read each cycle, sets the pace of that walk.
// A result is valid in the cycle after the emit state loads the output
// register. After reset and after every clear request the grid memory is
// swept to zero, one cell per cycle over all GRID_COLS * GRID_ROWS cells,
// before the next transfer is taken. A result waits in the output register
// while the receiver stalls, and the block keeps taking requests until it
// has a further result to give.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_nearest_star_match_top
  import gnsm_pkg::*;
#(
  parameter int unsigned GRID_COLS     = GridColsDef,
  parameter int unsigned GRID_ROWS     = GridRowsDef,
  parameter int unsigned MAX_TEMPLATES = MaxTmplDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [15:0]        pos_x_i,
  input  wire logic [15:0]        pos_y_i,
  input  wire logic signed [13:0] magnitude_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             query_number_o,
  output logic [1:0]              status_code_o,
  output logic [19:0]             dist_sq_o,
  output logic signed [14:0]      mag_diff_o
);

`include "grid_nearest_star_match_top_macros.svh"

  localparam int unsigned GDepth = GRID_COLS * GRID_ROWS;
  localparam int unsigned GAW    = $clog2(GDepth);
  localparam int unsigned TAW    = $clog2(MAX_TEMPLATES);
  localparam logic [GAW-1:0]    GLast  = GAW'(GDepth - 1);
  localparam logic [16:0]       XLim   = 17'((GRID_COLS - 1) * 16);
  localparam logic [16:0]       YLim   = 17'((GRID_ROWS - 1) * 16);
  localparam logic [17:0]       Rows16 = 18'(GRID_ROWS * 16);
  localparam logic [BndW-1:0]   ColsB  = BndW'(GRID_COLS);
  localparam logic [BndW-1:0]   RowsB  = BndW'(GRID_ROWS);
  localparam logic [OwnerW-1:0] MaxT   = OwnerW'(MAX_TEMPLATES);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLR    = 12'b000000000010,
    S_WSET   = 12'b000000000100,
    S_IWIN   = 12'b000000001000,
    S_ICRD   = 12'b000000010000,
    S_ICWR   = 12'b000000100000,
    S_QRD    = 12'b000001000000,
    S_QCELL  = 12'b000010000000,
    S_SCAN   = 12'b000100000000,
    S_DRAIN  = 12'b001000000000,
    S_DECIDE = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [8:0]         radius_q;
  logic [12:0]        tol_q;
  logic [15:0]        x_q, y_q;
  logic signed [13:0] mag_q;
  logic               ins_mode_q, shared_q;
  logic [OwnerW-1:0]  tcount_q, idx_q;
  logic [15:0]        qcount_q, qnum_q;
  logic [GAW-1:0]     clr_addr_q;
  logic [BndW-1:0]    row_q, col_q, bx_q, ex_q, ey_q;
  logic               g_vld_q, t_vld_q;
  logic [GAW-1:0]     g_addr_q;
  logic [1:0]         status_q;
  logic [19:0]        dist_q;
  logic signed [14:0] diff_q;
  logic               out_valid_q;

  logic               in_acc;
  logic               g_we, g_re, t_we, t_re;
  logic [GAW-1:0]     g_waddr, g_raddr;
  logic [CellW-1:0]   g_wdata, g_rdata, g_mod;
  logic [TmplW-1:0]   t_rdata;
  logic [OwnerW-1:0]  owner;
  logic               owner_ok, centre_hit, last_cell, load_out;
  eval_ctrl_t         ev_ctrl;
  eval_res_t          ev_res;

  logic [17:0]        w16, xs, ys, hx;
  logic [BndW-1:0]    bx_w, ex_w, by_w, ey_w;
  logic               win_ok, ctr_on_grid;
  logic [17:0]        rr;
  logic signed [15:0] diff16, tol16;
  logic               pos_miss, mag_miss;
  logic [16:0]        xin, yin;

  function automatic logic [GAW-1:0] cell_addr(input logic [BndW-1:0] r,
                                               input logic [BndW-1:0] c);
    return GAW'(32'(r) * 32'(GRID_COLS) + 32'(c));
  endfunction

  // Window bounds around the held position.
  assign w16 = {8'd0, ({1'b0, radius_q[8:4]} + 6'd2), 4'd0};
  assign xs  = {2'b00, x_q};
  assign ys  = {2'b00, y_q};
  assign hx  = (xs + w16 + 18'd24) >> 4;
  assign bx_w = (xs > w16) ? BndW'((xs - w16 + 18'd8) >> 4) : '0;
  assign ex_w = (hx <= 18'(GRID_COLS)) ? BndW'(hx) : ColsB;
  assign by_w = (ys > w16) ? BndW'((ys - w16 + 18'd8) >> 4) : '0;
  assign ey_w = ((ys + w16 + 18'd24) <= Rows16) ? BndW'((ys + w16 + 18'd8) >> 4)
                                                 : (RowsB - 1'b1);
  assign win_ok = (bx_w < ex_w) && (by_w <= ey_w);
  assign ctr_on_grid = ({1'b0, x_q[15:4]} < ColsB) && ({1'b0, y_q[15:4]} < RowsB);

  assign owner      = g_rdata[OwnerW-1:0];
  assign owner_ok   = (owner != '0) && ((owner - 1'b1) < MaxT);
  assign centre_hit = g_rdata[CentreB] && owner_ok;
  assign last_cell  = (col_q == (ex_q - 1'b1)) && (row_q == ey_q);
  assign g_mod = (owner == '0) ? {g_rdata[CentreB:SharedB], idx_q}
                               : (g_rdata | (CellW'(1) << SharedB));

  assign rr       = 18'(radius_q) * 18'(radius_q);
  assign pos_miss = (ev_res.best > DistW'(rr)) && (!shared_q || (ev_res.best < MissLimit));
  assign diff16   = {ev_res.diff[14], ev_res.diff};
  assign tol16    = $signed({3'b000, tol_q});
  assign mag_miss = (diff16 > tol16) || (diff16 < -tol16);

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign xin    = ({1'b0, pos_x_i} >= XLim) ? 17'd0 : {1'b0, pos_x_i};
  assign yin    = ({1'b0, pos_y_i} >= YLim) ? 17'd0 : {1'b0, pos_y_i};

  always_comb begin
    state_d       = state_q;
    g_we          = 1'b0;
    g_waddr       = g_addr_q;
    g_wdata       = '0;
    g_re          = 1'b0;
    g_raddr       = cell_addr(row_q, col_q);
    t_we          = 1'b0;
    t_re          = 1'b0;
    ev_ctrl.init  = 1'b0;
    ev_ctrl.limit = NoLimit;
    load_out      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            REQ_CLEAR:  state_d = S_CLR;
            REQ_INSERT: begin
              if (tcount_q < MaxT) begin
                t_we    = 1'b1;
                state_d = S_WSET;
              end
            end
            REQ_QUERY:  state_d = S_QRD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr_q;
        if (clr_addr_q == GLast) begin
          state_d = S_IDLE;
        end
      end
      S_WSET: state_d = win_ok ? S_IWIN : S_ICRD;
      S_IWIN: begin
        g_re = 1'b1;
        if (last_cell) begin
          state_d = S_ICRD;
        end
      end
      S_ICRD: begin
        if (!g_vld_q) begin
          if (ctr_on_grid) begin
            g_re    = 1'b1;
            g_raddr = cell_addr({1'b0, y_q[15:4]}, {1'b0, x_q[15:4]});
            state_d = S_ICWR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_ICWR: begin
        g_we    = 1'b1;
        g_waddr = cell_addr({1'b0, y_q[15:4]}, {1'b0, x_q[15:4]});
        g_wdata = {1'b1, g_rdata[SharedB], idx_q};
        state_d = S_IDLE;
      end
      S_QRD: begin
        g_re    = 1'b1;
        g_raddr = cell_addr({1'b0, y_q[15:4]}, {1'b0, x_q[15:4]});
        state_d = S_QCELL;
      end
      S_QCELL: begin
        if (owner == '0) begin
          state_d = S_EMIT;
        end else if (!g_rdata[SharedB]) begin
          if (owner_ok) begin
            t_re          = 1'b1;
            ev_ctrl.init  = 1'b1;
            ev_ctrl.limit = NoLimit;
            state_d       = S_DRAIN;
          end else begin
            state_d = S_IDLE;
          end
        end else if (win_ok) begin
          ev_ctrl.init  = 1'b1;
          ev_ctrl.limit = ScanLimit;
          state_d       = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        g_re = 1'b1;
        if (last_cell) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!g_vld_q && !t_vld_q && !ev_res.busy) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (shared_q && !ev_res.found) begin
          state_d = S_IDLE;
        end else if (pos_miss || mag_miss) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (g_vld_q && ins_mode_q) begin
      g_we    = 1'b1;
      g_waddr = g_addr_q;
      g_wdata = g_mod;
    end
    if (g_vld_q && !ins_mode_q && centre_hit) begin
      t_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      radius_q    <= RadiusRst;
      tol_q       <= TolRst;
      tcount_q    <= '0;
      qcount_q    <= '0;
      clr_addr_q  <= '0;
      ins_mode_q  <= 1'b0;
      g_vld_q     <= 1'b0;
      t_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MATCH_RADIUS: radius_q <= cfg_data_i[8:0];
          REG_MAG_TOL:      tol_q    <= cfg_data_i;
          default:          tol_q    <= tol_q;
        endcase
      end
      if (state_q == S_CLR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (in_acc) begin
        ins_mode_q <= (req_type_i == REQ_INSERT);
        if (req_type_i == REQ_CLEAR) begin
          tcount_q   <= '0;
          qcount_q   <= '0;
          clr_addr_q <= '0;
        end else if (req_type_i == REQ_QUERY) begin
          qcount_q <= qcount_q + 1'b1;
        end else if ((req_type_i == REQ_INSERT) && (tcount_q < MaxT)) begin
          tcount_q <= tcount_q + 1'b1;
        end
      end
      g_vld_q <= g_re && ((state_q == S_IWIN) || (state_q == S_SCAN));
      t_vld_q <= t_re;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    g_addr_q <= g_raddr;
    if (in_acc) begin
      x_q    <= (req_type_i == REQ_QUERY) ? xin[15:0] : pos_x_i;
      y_q    <= (req_type_i == REQ_QUERY) ? yin[15:0] : pos_y_i;
      mag_q  <= magnitude_i;
      idx_q  <= tcount_q + 1'b1;
      qnum_q <= qcount_q;
    end
    if ((state_q == S_WSET) || (state_q == S_QCELL)) begin
      row_q <= by_w;
      col_q <= bx_w;
      bx_q  <= bx_w;
      ex_q  <= ex_w;
      ey_q  <= ey_w;
    end else if ((state_q == S_IWIN) || (state_q == S_SCAN)) begin
      if (col_q == (ex_q - 1'b1)) begin
        col_q <= bx_q;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
    if (state_q == S_QCELL) begin
      shared_q <= g_rdata[SharedB];
      status_q <= ST_NONE;
      dist_q   <= '0;
      diff_q   <= '0;
    end
    if (state_q == S_DECIDE) begin
      status_q <= pos_miss ? ST_POS : ST_MAG;
      dist_q   <= (ev_res.best > DistW'(20'hFFFFF)) ? 20'hFFFFF : ev_res.best[19:0];
      diff_q   <= ev_res.diff;
    end
    if (load_out) begin
      query_number_o <= qnum_q;
      status_code_o  <= status_q;
      dist_sq_o      <= dist_q;
      mag_diff_o     <= diff_q;
    end
  end

  gnsm_ram #(
    .DEPTH (GDepth),
    .WIDTH (CellW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  gnsm_ram #(
    .DEPTH (MAX_TEMPLATES),
    .WIDTH (TmplW)
  ) u_tmpl (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (TAW'(tcount_q)),
    .wdata_i ({pos_x_i, pos_y_i, magnitude_i}),
    .re_i    (t_re),
    .raddr_i (TAW'(owner - 1'b1)),
    .rdata_o (t_rdata)
  );

  gnsm_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ev_ctrl),
    .vld_i  (t_vld_q),
    .tmpl_i (t_rdata),
    .qx_i   (x_q),
    .qy_i   (y_q),
    .qmag_i (mag_q),
    .res_o  (ev_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `GNSM_ASSERT(a_no_rw_clash, !(g_we && g_re && (g_waddr == g_raddr)), "grid read meets write")
  `GNSM_ASSERT(a_count_bound, tcount_q <= MaxT, "template count overflow")
  `GNSM_ASSERT(a_tmpl_rd_query, !t_re || !ins_mode_q, "template read during insert")
  `GNSM_ASSERT_NEXT(a_out_source, !out_valid_o && (state_q != S_EMIT), !out_valid_o, "result without emit")

endmodule

`default_nettype wire

FILE: tb/sv/tb_grid_nearest_star_match_top.sv
// ----------------------------------------------------------------------------
// Grid nearest star match testbench
// Drives clear, insert and query requests with random idling on both sides,
// predicts every empty-cell result and position or magnitude miss in a
// model of the grid held here, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_nearest_star_match_top
  import gnsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cols      = 1024;
  localparam int Rows      = 1024;
  localparam int MaxStars  = 4096;
  localparam int SettleCyc = 5000;
  localparam longint CycLimit = 40_000_000;

  typedef struct {
    logic [15:0]        qnum;
    status_e            status;
    logic [19:0]        dsq;
    logic signed [14:0] diff;
  } miss_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  reg_idx_e cfg_idx_i = REG_MATCH_RADIUS;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = REQ_CLEAR;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic signed [13:0] magnitude_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] query_number_o;
  logic [1:0] status_code_o;
  logic [19:0] dist_sq_o;
  logic signed [14:0] mag_diff_o;

  grid_nearest_star_match_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .pos_x_i, .pos_y_i, .magnitude_i,
    .out_valid_o, .out_stall_i, .query_number_o, .status_code_o, .dist_sq_o,
    .mag_diff_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Grid and star table as the block should hold them.
  logic [14:0] grid_map [int];
  logic [15:0] star_x [MaxStars];
  logic [15:0] star_y [MaxStars];
  int star_mag [MaxStars];
  int n_stars;
  logic [15:0] n_queries;
  logic [8:0] radius;
  logic [12:0] tolerance;
  miss_t miss_q [$];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_inserts = 0;
  int n_lookups = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [14:0] cell_at(int r, int c);
    int k;
    k = r * Cols + c;
    return grid_map.exists(k) ? grid_map[k] : 15'd0;
  endfunction

  function automatic bit window(int x, int y, output int bx, output int ex,
                                output int by, output int ey);
    int w16;
    int hi;
    w16 = ((int'(radius) >> 4) + 2) << 4;
    bx = (x > w16) ? ((x - w16 + 8) >> 4) : 0;
    hi = (x + w16 + 24) >> 4;
    ex = (hi <= Cols) ? hi : Cols;
    by = (y > w16) ? ((y - w16 + 8) >> 4) : 0;
    ey = (y + w16 + 24 <= Rows * 16) ? ((y + w16 + 8) >> 4) : Rows - 1;
    return (bx < ex) && (by <= ey);
  endfunction

  function automatic longint dist_sq(int t, int x, int y);
    longint dx;
    longint dy;
    dx = longint'(star_x[t]) - x;
    dy = longint'(star_y[t]) - y;
    return dx * dx + dy * dy;
  endfunction

  function automatic void paint_star(int x, int y, int mag);
    int bx, ex, by, ey, id, cx, cy;
    logic [14:0] v;
    if (n_stars >= MaxStars) return;
    star_x[n_stars] = x[15:0];
    star_y[n_stars] = y[15:0];
    star_mag[n_stars] = mag;
    n_stars++;
    id = n_stars;
    if (window(x, y, bx, ex, by, ey)) begin
      for (int r = by; r <= ey; r++) begin
        for (int c = bx; c < ex; c++) begin
          v = cell_at(r, c);
          if (v[12:0] == 0) v[12:0] = id[12:0];
          else v[SharedB] = 1'b1;
          grid_map[r * Cols + c] = v;
        end
      end
    end
    cx = x >> 4;
    cy = y >> 4;
    if (cx < Cols && cy < Rows) begin
      v = cell_at(cy, cx);
      v[12:0] = id[12:0];
      v[CentreB] = 1'b1;
      grid_map[cy * Cols + cx] = v;
    end
  endfunction

  function automatic void look_up_star(int x, int y, int mag);
    logic [14:0] v;
    longint d, best, rr;
    int diff, bx, ex, by, ey, t;
    bit found;
    miss_t m;
    m.qnum = n_queries;
    n_queries++;
    if (x >= (Cols - 1) * 16) x = 0;
    if (y >= (Rows - 1) * 16) y = 0;
    v = cell_at(y >> 4, x >> 4);
    rr = longint'(radius) * radius;
    d = 0;
    diff = 0;
    if (v[12:0] == 0) begin
      m.status = ST_NONE;
    end else begin
      if (!v[SharedB]) begin
        t = int'(v[12:0]) - 1;
        d = dist_sq(t, x, y);
        diff = star_mag[t] - mag;
        found = 1'b1;
      end else begin
        best = 2560000;
        found = 1'b0;
        if (window(x, y, bx, ex, by, ey)) begin
          for (int r = by; r <= ey; r++) begin
            for (int c = bx; c < ex; c++) begin
              v = cell_at(r, c);
              if (v[CentreB] && v[12:0] != 0) begin
                t = int'(v[12:0]) - 1;
                if (dist_sq(t, x, y) < best) begin
                  best = dist_sq(t, x, y);
                  diff = star_mag[t] - mag;
                  found = 1'b1;
                end
              end
            end
          end
        end
        d = best;
        if (found && !(d < 2304000)) rr = d;
      end
      if (!found) return;
      if (d > rr) m.status = ST_POS;
      else if (diff > int'(tolerance) || diff < -int'(tolerance)) m.status = ST_MAG;
      else return;
    end
    m.dsq = (d > 64'hFFFFF) ? 20'hFFFFF : d[19:0];
    m.diff = diff[14:0];
    miss_q = {miss_q, m};
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    miss_t m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (miss_q.size() == 0) begin
        errors++;
        $error("result transfer with none expected, query_number %0d", query_number_o);
      end else begin
        m = miss_q.pop_front();
        if (query_number_o !== m.qnum) begin
          errors++;
          $error("query_number expected %0d actual %0d", m.qnum, query_number_o);
        end
        if (status_code_o !== m.status) begin
          errors++;
          $error("status_code expected %0d actual %0d", m.status, status_code_o);
        end
        if (dist_sq_o !== m.dsq) begin
          errors++;
          $error("dist_sq expected %0d actual %0d", m.dsq, dist_sq_o);
        end
        if (mag_diff_o !== m.diff) begin
          errors++;
          $error("mag_diff expected %0d actual %0d", m.diff, mag_diff_o);
        end
      end
    end
  end

  // Receiver stall: random bursts, quiet stretches and a long hold on request.
  int stall_left = 0;
  int quiet_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall_i <= 1'b1;
    end else begin
      quiet_left = $urandom_range(5, 200);
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_req(req_e req, int x, int y, int mag);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    pos_x_i <= x[15:0];
    pos_y_i <= y[15:0];
    magnitude_i <= mag[13:0];
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    case (req)
      REQ_CLEAR: begin
        grid_map.delete();
        n_stars = 0;
        n_queries = 0;
      end
      REQ_INSERT: begin
        n_inserts++;
        paint_star(x & 16'hFFFF, y & 16'hFFFF, int'($signed(mag[13:0])));
      end
      REQ_QUERY: begin
        n_lookups++;
        look_up_star(x & 16'hFFFF, y & 16'hFFFF, int'($signed(mag[13:0])));
      end
      default: ;
    endcase
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (miss_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_limits(int r, int tol);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MATCH_RADIUS;
    cfg_data_i <= r[CfgW-1:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_MAG_TOL;
    cfg_data_i <= tol[CfgW-1:0];
    radius = r[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tolerance = tol[12:0];
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(REQ_INSERT, 160, 160, 0);
    send_req(REQ_QUERY, 160, 160, 0);
    send_req(REQ_QUERY, 160, 160, 8191);
    send_req(REQ_QUERY, 224, 160, 0);
    send_req(REQ_QUERY, 8000, 8000, 0);
    send_req(REQ_QUERY, 16'hFFFF, 16'hFFFF, -8192);
    send_req(REQ_INSERT, 192, 160, -8192);
    send_req(REQ_QUERY, 176, 160, 0);
    send_req(REQ_QUERY, 176, 176, -8192);
    send_req(req_e'(2'd3), 16'hFFFF, 16'hFFFF, -1);
    send_req(REQ_INSERT, 16400, 16000, 100);
    send_req(REQ_QUERY, 16360, 16000, 0);
    send_req(REQ_INSERT, 0, 0, 8191);
    send_req(REQ_QUERY, 0, 0, -8192);
    send_req(REQ_CLEAR, 0, 0, 0);
    send_req(REQ_QUERY, 160, 160, 0);
    set_limits(511, 0);
    send_req(REQ_INSERT, 8000, 8000, 5);
    send_req(REQ_QUERY, 8100, 8000, 5);
    send_req(REQ_QUERY, 8000, 8400, 4);
    set_limits(0, 8191);
    send_req(REQ_QUERY, 8001, 8000, -8192);
    send_req(REQ_INSERT, 8010, 8020, 3);
    send_req(REQ_QUERY, 8005, 8015, 3);
  endtask

  task automatic test_random(int n_req);
    int sent, base_x, base_y, span;
    sent = 0;
    span = ((int'(radius) >> 4) + 4) * 16;
    while (sent < n_req) begin
      case ($urandom_range(0, 3))
        0: base_x = 0;
        1: base_x = (Cols - 8) * 16;
        default: base_x = $urandom_range(0, (Cols - 1) * 16);
      endcase
      base_y = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (Rows - 1) * 16);
      repeat ($urandom_range(1, 5)) begin
        send_req(REQ_INSERT, base_x + $urandom_range(0, span),
                 base_y + $urandom_range(0, span), $urandom_range(0, 16383));
        sent++;
      end
      repeat ($urandom_range(3, 8)) begin
        send_req(REQ_QUERY, base_x + $urandom_range(0, span),
                 base_y + $urandom_range(0, span), $urandom_range(0, 16383));
        sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_req(($urandom_range(0, 1) == 0) ? req_e'(2'd3) : REQ_QUERY,
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 16383));
        sent++;
      end
    end
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    @(posedge clk_i);
    send_req(REQ_INSERT, 4000, 4000, 0);
    repeat (40) send_req(REQ_QUERY, 4000 + $urandom_range(0, 200), 4000, 8191);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    set_limits(0, 100);
    for (int i = 0; i < 16; i++)
      send_req(REQ_INSERT, 16'hFF00 | $urandom_range(0, 255),
               $urandom_range(0, 65535), $urandom_range(0, 16383));
    repeat (20) begin
      send_req(REQ_INSERT, 3000, 3000, 0);
      send_req(REQ_QUERY, 3000 + $urandom_range(0, 40), 3000, 500);
    end
  endtask

  initial begin
    radius = RadiusRst;
    tolerance = TolRst;
    n_stars = 0;
    n_queries = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_limits(48, 128);
    test_random(300);
    set_limits($urandom_range(1, 160), $urandom_range(1, 8190));
    test_random(300);
    set_limits(511, 8191);
    test_random(40);
    set_limits(32, 64);
    test_output_hold();
    drain_results();
    test_random(100);
    test_back_to_back();
    drain_results();
    $display("Covered %0d transfers: %0d inserts, %0d queries, %0d miss results.",
             n_items, n_inserts, n_lookups, n_results);
    $display("Register extremes, off-grid inserts, a long output hold and gapless traffic were included.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
